### hw/rtl/sbti_pkg.sv
// Shared types and constants for the swept box time of impact unit.
package sbti_pkg;

   localparam int AXES        = 3;
   localparam int FRAC_BITS   = 16;
   localparam int MAG_W       = 31;
   localparam int DIVIDEND_W  = MAG_W + FRAC_BITS;
   localparam int DIVISOR_W   = 32;
   localparam int DIV_STEPS   = DIVIDEND_W;

   typedef enum logic [2:0] {
      AXIS_NONE = 3'd0,
      AXIS_POS_X = 3'd1,
      AXIS_NEG_X = 3'd2,
      AXIS_POS_Y = 3'd3,
      AXIS_NEG_Y = 3'd4,
      AXIS_POS_Z = 3'd5,
      AXIS_NEG_Z = 3'd6
   } axis_code_type;

   typedef struct packed {
      logic signed [31:0] gap_ahead_x;
      logic signed [31:0] gap_ahead_y;
      logic signed [31:0] gap_ahead_z;
      logic signed [31:0] gap_behind_x;
      logic signed [31:0] gap_behind_y;
      logic signed [31:0] gap_behind_z;
      logic signed [31:0] rel_vel_x;
      logic signed [31:0] rel_vel_y;
      logic signed [31:0] rel_vel_z;
      logic [2:0]         slope_axis_mask;
   } req_type;

   typedef struct packed {
      logic signed [31:0] contact_time;
      logic               contact_valid;
      logic [2:0]         contact_axis;
      logic               all_overlapped;
   } rsp_type;

   // Per-axis information that travels alongside the quotient.
   typedef struct packed {
      logic          counts;
      logic          negative;
      axis_code_type code;
   } axis_side_type;

endpackage

### hw/rtl/sbti_divider.sv
// Fully pipelined restoring divider, one quotient bit per stage.
module sbti_divider (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [sbti_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [sbti_pkg::DIVISOR_W-1:0]   divisor,
   output logic [sbti_pkg::DIVIDEND_W-1:0]  quotient
);
   import sbti_pkg::*;

   logic [DIVIDEND_W-1:0] quo_ff [0:DIV_STEPS];
   logic [DIVISOR_W-1:0]  rem_ff [0:DIV_STEPS];
   logic [DIVISOR_W-1:0]  dvs_ff [0:DIV_STEPS];
   logic [DIVIDEND_W-1:0] quo_in [1:DIV_STEPS];
   logic [DIVISOR_W-1:0]  rem_in [1:DIV_STEPS];

   always_comb begin
      logic [DIVISOR_W:0] shifted;
      for (int k = 0; k < DIV_STEPS; k++) begin
         shifted = {rem_ff[k], quo_ff[k][DIVIDEND_W-1]};
         if (shifted >= {1'b0, dvs_ff[k]}) begin
            rem_in[k+1] = DIVISOR_W'(shifted - {1'b0, dvs_ff[k]});
            quo_in[k+1] = {quo_ff[k][DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in[k+1] = shifted[DIVISOR_W-1:0];
            quo_in[k+1] = {quo_ff[k][DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quo_ff[0] <= dividend;
         rem_ff[0] <= '0;
         dvs_ff[0] <= divisor;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            quo_ff[k] <= quo_in[k];
            rem_ff[k] <= rem_in[k];
            dvs_ff[k] <= dvs_ff[k-1];
         end
      end
   end

   assign quotient = quo_ff[DIV_STEPS];

endmodule

### hw/rtl/swept_box_time_of_impact_unit.sv
// Top level of the swept box time of impact unit.
// The unit takes one request per clock cycle while req_stall is low and returns one
// result per request, in order. Three parallel restoring dividers of 47 one-bit
// stages each, one per axis, form a single pipeline with a prepare stage ahead and
// a post stage and a select stage behind. The whole pipeline advances together:
// while a finished result waits on rsp_stall, the unit raises req_stall. The frame
// delta register is written through csr_write_enable and should only be changed
// while no request is in flight.
module swept_box_time_of_impact_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sbti_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sbti_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [30:0]       csr_write_data
);
   import sbti_pkg::*;

   localparam logic [30:0] FRAME_DELTA_RESET = 31'd2185;

   logic [30:0]   frame_delta_ff;
   logic          enable;

   // Prepare stage: decide per axis whether the boxes are separated and closing,
   // and form the unsigned dividend and divisor.
   logic signed [31:0]    gap_ahead [AXES];
   logic signed [31:0]    gap_behind [AXES];
   logic signed [31:0]    vel [AXES];
   axis_side_type         side_in [AXES];
   logic [DIVIDEND_W-1:0] dividend [AXES];
   logic [DIVISOR_W-1:0]  divisor [AXES];
   logic [DIVIDEND_W-1:0] quotient [AXES];

   // Side information travels beside the divider stages.
   axis_side_type side_ff [0:DIV_STEPS][AXES];
   logic          vld_ff [0:DIV_STEPS];

   // Post stage: saturated signed time per axis.
   logic signed [31:0] time_in [AXES];
   logic signed [31:0] time_ff [AXES];
   axis_side_type      post_side_ff [AXES];
   logic               post_vld_ff;

   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_delta_ff <= FRAME_DELTA_RESET;
      end else if (csr_write_enable) begin
         frame_delta_ff <= csr_write_data;
      end
   end

   always_comb begin
      logic signed [31:0] gap;
      logic [30:0]        mag;
      gap_ahead  = '{req_data.gap_ahead_x, req_data.gap_ahead_y, req_data.gap_ahead_z};
      gap_behind = '{req_data.gap_behind_x, req_data.gap_behind_y, req_data.gap_behind_z};
      vel        = '{req_data.rel_vel_x, req_data.rel_vel_y, req_data.rel_vel_z};
      for (int a = 0; a < AXES; a++) begin
         side_in[a].counts   = 1'b0;
         side_in[a].negative = 1'b0;
         side_in[a].code     = AXIS_NONE;
         gap                 = gap_ahead[a];
         divisor[a]          = DIVISOR_W'(1);
         if (!req_data.slope_axis_mask[a]) begin
            if (vel[a] < 0 && gap_ahead[a] >= 0) begin
               side_in[a].counts = 1'b1;
               side_in[a].code   = axis_code_type'(3'(2 * a + 1));
               gap               = gap_ahead[a];
               divisor[a]        = 32'(0) - 32'(vel[a]);
            end else if (vel[a] > 0 && gap_behind[a] >= 0) begin
               side_in[a].counts = 1'b1;
               side_in[a].code   = axis_code_type'(3'(2 * a + 2));
               gap               = gap_behind[a];
               divisor[a]        = 32'(vel[a]);
            end
         end
         // A gap of zero gives a numerator of minus one LSB.
         if (gap == 0) begin
            side_in[a].negative = 1'b1;
            mag                 = 31'd1;
         end else begin
            mag = gap[30:0] - 31'd1;
         end
         dividend[a] = {mag, FRAC_BITS'(0)};
      end
   end

   for (genvar g = 0; g < AXES; g++) begin : g_div
      sbti_divider u_div (
         .clock    (clock),
         .enable   (enable),
         .dividend (dividend[g]),
         .divisor  (divisor[g]),
         .quotient (quotient[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (enable) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= side_in;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Saturate positive quotients, negate the small negative ones and give zero for axes that do not count.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         if (!side_ff[DIV_STEPS][a].counts) begin
            time_in[a] = '0;
         end else if (side_ff[DIV_STEPS][a].negative) begin
            time_in[a] = 32'(0) - quotient[a][31:0];
         end else if (quotient[a][DIVIDEND_W-1:31] != '0) begin
            time_in[a] = 32'h7FFF_FFFF;
         end else begin
            time_in[a] = {1'b0, quotient[a][30:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= 1'b0;
      end else if (enable) begin
         post_vld_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         time_ff      <= time_in;
         post_side_ff <= side_ff[DIV_STEPS];
      end
   end

   // Pick the latest contact time; ties go to X, then Y, then Z.
   always_comb begin
      logic signed [31:0] t;
      logic               none;
      axis_code_type      code;
      none = !post_side_ff[0].counts && !post_side_ff[1].counts && !post_side_ff[2].counts;
      if (none) begin
         t    = '0;
         code = AXIS_NONE;
      end else if (time_ff[0] >= time_ff[1] && time_ff[0] >= time_ff[2]) begin
         t    = time_ff[0];
         code = post_side_ff[0].code;
      end else if (time_ff[1] >= time_ff[0] && time_ff[1] >= time_ff[2]) begin
         t    = time_ff[1];
         code = post_side_ff[1].code;
      end else begin
         t    = time_ff[2];
         code = post_side_ff[2].code;
      end
      rsp_in.contact_time   = t;
      rsp_in.contact_valid  = t[31] || (t[30:0] <= frame_delta_ff);
      rsp_in.contact_axis   = code;
      rsp_in.all_overlapped = none;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= post_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
